// File: hw/rtl/token_boundary_scanner_macros.svh
// Assertion macros for the token boundary scanner.
// No dependencies; included by files that carry concurrent assertions.
`ifndef TOKEN_BOUNDARY_SCANNER_MACROS_SVH
`define TOKEN_BOUNDARY_SCANNER_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked assertion, disabled while reset is asserted (active low)
`define TBS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("token_boundary_scanner: assertion failed");
// Clocked assertion that also holds during reset
`define TBS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("token_boundary_scanner: assertion failed");
`else
`define TBS_ASSERT(lbl, clk, rstn, prop)
`define TBS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: hw/rtl/tbs_pkg.sv
// Shared types and constants for the token boundary scanner.
// No dependencies; used by every other RTL file except the macros header.
package tbs_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned PosW  = 16;
  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  // Register byte offsets
  localparam logic [AddrW-1:0] RegHalt = 3'd0;

  // Characters of interest
  localparam logic [CharW-1:0] ChZero  = 8'h00;
  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChNl    = 8'h0A;
  localparam logic [CharW-1:0] ChQuote = 8'h22;
  localparam logic [CharW-1:0] ChLBrk  = 8'h5B;
  localparam logic [CharW-1:0] ChRBrk  = 8'h5D;
  localparam logic [CharW-1:0] ChLBrc  = 8'h7B;
  localparam logic [CharW-1:0] ChRBrc  = 8'h7D;
  localparam logic [CharW-1:0] ChLPar  = 8'h28;
  localparam logic [CharW-1:0] ChRPar  = 8'h29;
  localparam logic [CharW-1:0] ChLt    = 8'h3C;
  localparam logic [CharW-1:0] ChGt    = 8'h3E;
  localparam logic [CharW-1:0] ChDot   = 8'h2E;
  localparam logic [CharW-1:0] ChStar  = 8'h2A;
  localparam logic [CharW-1:0] ChBang  = 8'h21;
  localparam logic [CharW-1:0] ChQmark = 8'h3F;
  localparam logic [CharW-1:0] ChUscore = 8'h5F;
  localparam logic [CharW-1:0] ChPlus  = 8'h2B;
  localparam logic [CharW-1:0] ChHash  = 8'h23;
  localparam logic [CharW-1:0] ChEq    = 8'h3D;
  localparam logic [CharW-1:0] ChColon = 8'h3A;
  localparam logic [CharW-1:0] ChMinus = 8'h2D;
  localparam logic [CharW-1:0] ChSlash = 8'h2F;
  localparam logic [CharW-1:0] ChLowA  = 8'h61;
  localparam logic [CharW-1:0] ChLowZ  = 8'h7A;
  localparam logic [CharW-1:0] ChUpA   = 8'h41;
  localparam logic [CharW-1:0] ChUpZ   = 8'h5A;
  localparam logic [CharW-1:0] Ch0     = 8'h30;
  localparam logic [CharW-1:0] Ch9     = 8'h39;

  localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};

  typedef enum logic [1:0] {
    ROLE_SPACE = 2'd0,
    ROLE_START = 2'd1,
    ROLE_CONT  = 2'd2,
    ROLE_END   = 2'd3
  } char_role_e;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_PUNCT   = 3'd1,
    KIND_STRING  = 3'd2,
    KIND_SYMBOL  = 3'd3,
    KIND_UNKNOWN = 3'd4
  } token_kind_e;

  // Scanner mode, one-hot
  typedef enum logic [3:0] {
    MODE_BETWEEN = 4'b0001,
    MODE_STRING  = 4'b0010,
    MODE_SYMBOL  = 4'b0100,
    MODE_ENDED   = 4'b1000
  } scan_mode_e;

  // Character class flags
  typedef struct packed {
    logic is_zero;
    logic is_space;   // space or newline
    logic is_str_end; // quote or newline
    logic is_quote;
    logic is_alnum;
    logic is_sym_cont;
    logic is_punct;
  } char_class_t;

  // One classified character
  typedef struct packed {
    char_role_e       role;
    token_kind_e      kind;
    logic             closes;
    logic [PosW-1:0]  pos;
    logic [CharW-1:0] ch;
  } scan_result_t;

  // Core status towards the top level
  typedef struct packed {
    logic ended;
    logic token_open;
  } scan_status_t;

endpackage

// File: hw/rtl/tbs_if.sv
// Valid/ready stream interfaces for the token boundary scanner.
// Depends on tbs_pkg for field widths.
interface tbs_in_if;
  logic                      valid;
  logic                      ready;
  logic [tbs_pkg::CharW-1:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

interface tbs_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                char_role;
  logic [2:0]                token_kind;
  logic                      closes_previous;
  logic [tbs_pkg::PosW-1:0]  char_position;
  logic [tbs_pkg::CharW-1:0] char_out;

  modport source (output valid, output char_role, output token_kind,
                  output closes_previous, output char_position,
                  output char_out, input ready);
  modport sink   (input valid, input char_role, input token_kind,
                  input closes_previous, input char_position,
                  input char_out, output ready);
endinterface

// File: hw/rtl/tbs_char_class.sv
// Character classifier: decodes one byte into class flags.
// Depends on tbs_pkg.
module tbs_char_class (
  input  logic [tbs_pkg::CharW-1:0] ch_i,
  output tbs_pkg::char_class_t      cls_o
);

  logic alnum;
  logic nl;

  assign nl    = (ch_i == tbs_pkg::ChNl);
  assign alnum = (ch_i >= tbs_pkg::ChLowA && ch_i <= tbs_pkg::ChLowZ) ||
                 (ch_i >= tbs_pkg::ChUpA  && ch_i <= tbs_pkg::ChUpZ)  ||
                 (ch_i >= tbs_pkg::Ch0    && ch_i <= tbs_pkg::Ch9);

  // Flag decode
  always_comb begin
    cls_o.is_zero     = (ch_i == tbs_pkg::ChZero);
    cls_o.is_space    = (ch_i == tbs_pkg::ChSpace) || nl;
    cls_o.is_quote    = (ch_i == tbs_pkg::ChQuote);
    cls_o.is_str_end  = (ch_i == tbs_pkg::ChQuote) || nl;
    cls_o.is_alnum    = alnum;
    cls_o.is_sym_cont = alnum ||
                        (ch_i == tbs_pkg::ChUscore) || (ch_i == tbs_pkg::ChPlus) ||
                        (ch_i == tbs_pkg::ChHash)   || (ch_i == tbs_pkg::ChEq)   ||
                        (ch_i == tbs_pkg::ChColon)  || (ch_i == tbs_pkg::ChMinus) ||
                        (ch_i == tbs_pkg::ChSlash);
    cls_o.is_punct    = (ch_i == tbs_pkg::ChLBrk) || (ch_i == tbs_pkg::ChRBrk) ||
                        (ch_i == tbs_pkg::ChLBrc) || (ch_i == tbs_pkg::ChRBrc) ||
                        (ch_i == tbs_pkg::ChLPar) || (ch_i == tbs_pkg::ChRPar) ||
                        (ch_i == tbs_pkg::ChLt)   || (ch_i == tbs_pkg::ChGt)   ||
                        (ch_i == tbs_pkg::ChDot)  || (ch_i == tbs_pkg::ChStar) ||
                        (ch_i == tbs_pkg::ChBang) || (ch_i == tbs_pkg::ChQmark);
  end

endmodule

// File: hw/rtl/tbs_scan_core.sv
// Scanner state machine: mode, open-token flag and position counter,
// producing one classified result per accepted beat. Depends on tbs_pkg.
module tbs_scan_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic                       halt_i,
  input  logic [tbs_pkg::CharW-1:0]  ch_i,
  input  tbs_pkg::char_class_t       cls_i,
  output tbs_pkg::scan_result_t      res_o,
  output tbs_pkg::scan_status_t      status_o
);

  tbs_pkg::scan_mode_e      mode_q, mode_d;
  logic                     open_q, open_d;
  logic [tbs_pkg::PosW-1:0] pos_q, pos_d;

  // Next state and result for the character on the input
  always_comb begin
    mode_d       = mode_q;
    open_d       = open_q;
    res_o.role   = tbs_pkg::ROLE_END;
    res_o.kind   = tbs_pkg::KIND_NONE;
    res_o.closes = 1'b0;
    res_o.pos    = pos_q;
    res_o.ch     = ch_i;

    priority if (halt_i || mode_q == tbs_pkg::MODE_ENDED) begin
      // end reported, mode and open flag left alone; position still advances
    end else if (cls_i.is_zero) begin
      res_o.closes = open_q;
      mode_d       = tbs_pkg::MODE_ENDED;
      open_d       = 1'b0;
    end else if (mode_q == tbs_pkg::MODE_STRING) begin
      res_o.role = tbs_pkg::ROLE_CONT;
      res_o.kind = tbs_pkg::KIND_STRING;
      if (cls_i.is_str_end) begin
        mode_d = tbs_pkg::MODE_BETWEEN;
      end
    end else if (mode_q == tbs_pkg::MODE_SYMBOL && cls_i.is_sym_cont) begin
      res_o.role = tbs_pkg::ROLE_CONT;
      res_o.kind = tbs_pkg::KIND_SYMBOL;
    end else begin
      // between tokens, or a symbol has just ended
      res_o.closes = open_q;
      mode_d       = tbs_pkg::MODE_BETWEEN;
      if (cls_i.is_space) begin
        res_o.role = tbs_pkg::ROLE_SPACE;
        open_d     = 1'b0;
      end else begin
        res_o.role = tbs_pkg::ROLE_START;
        open_d     = 1'b1;
        priority if (cls_i.is_punct) begin
          res_o.kind = tbs_pkg::KIND_PUNCT;
        end else if (cls_i.is_quote) begin
          res_o.kind = tbs_pkg::KIND_STRING;
          mode_d     = tbs_pkg::MODE_STRING;
        end else if (cls_i.is_alnum) begin
          res_o.kind = tbs_pkg::KIND_SYMBOL;
          mode_d     = tbs_pkg::MODE_SYMBOL;
        end else begin
          res_o.kind = tbs_pkg::KIND_UNKNOWN;
        end
      end
    end
  end

  // Saturating position counter
  assign pos_d = (pos_q == tbs_pkg::PosMax) ? pos_q : pos_q + 1'b1;

  // State registers, updated per accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= tbs_pkg::MODE_BETWEEN;
      open_q <= 1'b0;
      pos_q  <= '0;
    end else if (step_i) begin
      mode_q <= mode_d;
      open_q <= open_d;
      pos_q  <= pos_d;
    end
  end

  assign status_o.ended      = (mode_q == tbs_pkg::MODE_ENDED);
  assign status_o.token_open = open_q;

endmodule

// File: hw/rtl/token_boundary_scanner.sv
// Token boundary scanner: one character in, one labelled result out per beat.
// The result of an input beat is captured in the output register as the beat is accepted.
// Throughput: 1 beat per cycle while the output is ready; the output register refills in the cycle it drains.
// Reset (rst_ni, async, low): mode between tokens, no open token,
// position 0, halt 0, output register empty. No clearing pass.
// Depends on tbs_pkg, tbs_if, tbs_char_class, tbs_scan_core and the macros header.
`include "token_boundary_scanner_macros.svh"

module token_boundary_scanner (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  tbs_in_if.sink                    in_i,
  tbs_out_if.source                 out_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [tbs_pkg::AddrW-1:0] paddr,
  input  logic [tbs_pkg::DataW-1:0] pwdata,
  output logic [tbs_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  logic                  halt_q;
  logic                  in_fire;
  logic                  out_valid_q;
  tbs_pkg::scan_result_t res_d, res_q;
  tbs_pkg::char_class_t  cls;
  tbs_pkg::scan_status_t status;
  logic                  reg_hit;

  // Configuration port: halt register at word 0
  assign pready  = 1'b1;
  assign reg_hit = (paddr[tbs_pkg::AddrW-1] == tbs_pkg::RegHalt[tbs_pkg::AddrW-1]);
  assign prdata  = reg_hit ? {{(tbs_pkg::DataW-1){1'b0}}, halt_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halt_q <= 1'b0;
    end else if (psel && penable && pwrite && reg_hit) begin
      halt_q <= pwdata[0];
    end
  end

  // Input handshake: take a beat whenever the output register frees up
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  tbs_char_class u_class (
    .ch_i  (in_i.char_in),
    .cls_o (cls)
  );

  tbs_scan_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (in_fire),
    .halt_i   (halt_q),
    .ch_i     (in_i.char_in),
    .cls_i    (cls),
    .res_o    (res_d),
    .status_o (status)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.char_role       = res_q.role;
  assign out_o.token_kind      = res_q.kind;
  assign out_o.closes_previous = res_q.closes;
  assign out_o.char_position   = res_q.pos;
  assign out_o.char_out        = res_q.ch;

  // Checks
  `TBS_ASSERT(a_end_sticky, clk_i, rst_ni, status.ended |=> status.ended)
  `TBS_ASSERT(a_no_kind_off_token, clk_i, rst_ni, (out_valid_q && (res_q.role == tbs_pkg::ROLE_END || res_q.role == tbs_pkg::ROLE_SPACE)) |-> (res_q.kind == tbs_pkg::KIND_NONE))
  `TBS_ASSERT(a_ended_closed, clk_i, rst_ni, status.ended |-> !status.token_open)
  `TBS_ASSERT_ALWAYS(a_ready_when_empty, clk_i, !out_valid_q |-> in_i.ready)

endmodule

// File: tb/sv/tb_token_boundary_scanner.sv
// Self-checking testbench for token_boundary_scanner: streams text through the
// character channel, predicts every labelled beat and checks it field by field.
// Depends on tbs_pkg, the tbs_in_if/tbs_out_if interfaces and the scanner RTL.
module tb_token_boundary_scanner;
  timeunit 1ns;
  timeprecision 1ps;

  import tbs_pkg::*;

  localparam int unsigned CycleLimit   = 600000;
  localparam int unsigned HoldAtBeat   = 150;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned StreamLength = 1000;

  // Second register slot: nothing lives there, writes must be dropped
  localparam logic [AddrW-1:0] RegSpare = AddrW'(4);

  localparam logic [CharW-1:0] ChTab = 8'h09;
  localparam logic [CharW-1:0] ChCr  = 8'h0D;
  localparam logic [CharW-1:0] ChAt  = 8'h40;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  tbs_in_if  in_bus ();
  tbs_out_if out_bus ();

  token_boundary_scanner DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Characters waiting to be offered, and labels waiting to come back
  logic [CharW-1:0] pending_chars [$];
  scan_result_t     expected_labels [$];
  int unsigned      queued_total = 0;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  logic        in_beat = 1'b0;
  int unsigned out_beats = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;

  // Predicted scanner state
  logic             halt_reg;
  scan_mode_e       cur_mode;
  logic             tok_open;
  logic [PosW-1:0]  next_pos;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    $display("MISMATCH %s: got %0h, want %0h (cycle %0d)", what, got, want, cycle_count);
  endtask

  // ---------------------------------------------------------------------------
  // Character classes
  // ---------------------------------------------------------------------------
  function automatic logic char_is_alnum(input logic [CharW-1:0] c);
    return (c >= ChLowA && c <= ChLowZ) || (c >= ChUpA && c <= ChUpZ) ||
           (c >= Ch0 && c <= Ch9);
  endfunction

  function automatic logic char_is_punct(input logic [CharW-1:0] c);
    return c == ChLBrk || c == ChRBrk || c == ChLBrc || c == ChRBrc ||
           c == ChLPar || c == ChRPar || c == ChLt || c == ChGt ||
           c == ChDot || c == ChStar || c == ChBang || c == ChQmark;
  endfunction

  function automatic logic char_extends_symbol(input logic [CharW-1:0] c);
    return char_is_alnum(c) || c == ChUscore || c == ChPlus || c == ChHash ||
           c == ChEq || c == ChColon || c == ChMinus || c == ChSlash;
  endfunction

  // Label one accepted character and advance the predicted state
  function automatic scan_result_t classify_char(input logic [CharW-1:0] c);
    scan_result_t r;
    r.role   = ROLE_END;
    r.kind   = KIND_NONE;
    r.closes = 1'b0;
    r.pos    = next_pos;
    r.ch     = c;
    if (next_pos != PosMax) next_pos = next_pos + 1'b1;

    // halted or past the end: end reported, mode and open flag kept, position advances
    if (!halt_reg && cur_mode != MODE_ENDED) begin
      if (c == ChZero) begin
        r.closes = tok_open;
        cur_mode = MODE_ENDED;
        tok_open = 1'b0;
      end else if (cur_mode == MODE_STRING) begin
        r.role = ROLE_CONT;
        r.kind = KIND_STRING;
        if (c == ChQuote || c == ChNl) cur_mode = MODE_BETWEEN;
      end else if (cur_mode == MODE_SYMBOL && char_extends_symbol(c)) begin
        r.role = ROLE_CONT;
        r.kind = KIND_SYMBOL;
      end else begin
        // between tokens, or the open symbol just ended
        r.closes = tok_open;
        cur_mode = MODE_BETWEEN;
        if (c == ChSpace || c == ChNl) begin
          r.role   = ROLE_SPACE;
          tok_open = 1'b0;
        end else begin
          r.role = ROLE_START;
          if (char_is_punct(c)) begin
            r.kind = KIND_PUNCT;
          end else if (c == ChQuote) begin
            r.kind   = KIND_STRING;
            cur_mode = MODE_STRING;
          end else if (char_is_alnum(c)) begin
            r.kind   = KIND_SYMBOL;
            cur_mode = MODE_SYMBOL;
          end else begin
            r.kind = KIND_UNKNOWN;
          end
          tok_open = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Text generation
  // ---------------------------------------------------------------------------
  task automatic offer(input logic [CharW-1:0] c);
    pending_chars.push_back(c);
    queued_total++;
  endtask

  function automatic logic [CharW-1:0] random_alnum();
    case ($urandom_range(2))
      0:       return CharW'(ChLowA + $urandom_range(25));
      1:       return CharW'(ChUpA + $urandom_range(25));
      default: return CharW'(Ch0 + $urandom_range(9));
    endcase
  endfunction

  function automatic logic [CharW-1:0] random_punct();
    case ($urandom_range(11))
      0:       return ChLBrk;
      1:       return ChRBrk;
      2:       return ChLBrc;
      3:       return ChRBrc;
      4:       return ChLPar;
      5:       return ChRPar;
      6:       return ChLt;
      7:       return ChGt;
      8:       return ChDot;
      9:       return ChStar;
      10:      return ChBang;
      default: return ChQmark;
    endcase
  endfunction

  function automatic logic [CharW-1:0] random_sym_extra();
    case ($urandom_range(6))
      0:       return ChUscore;
      1:       return ChPlus;
      2:       return ChHash;
      3:       return ChEq;
      4:       return ChColon;
      5:       return ChMinus;
      default: return ChSlash;
    endcase
  endfunction

  // Mostly well-formed tokens with random content, some noise and broken strings.
  // Zero bytes only where zeros_ok, i.e. while halted.
  task automatic queue_text(input int unsigned n_chars, input bit zeros_ok);
    int unsigned target;
    int unsigned pick;
    int unsigned lo;
    target = queued_total + n_chars;
    lo = zeros_ok ? 0 : 1;
    while (queued_total < target) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        repeat ($urandom_range(1, 3)) offer($urandom_range(1) ? ChSpace : ChNl);
      end else if (pick < 30) begin
        offer(random_punct());
      end else if (pick < 55) begin
        offer(random_alnum());
        repeat ($urandom_range(8))
          offer(($urandom_range(3) == 0) ? random_sym_extra() : random_alnum());
      end else if (pick < 75) begin
        offer(ChQuote);
        repeat ($urandom_range(10)) offer(CharW'($urandom_range(255, lo)));
        pick = $urandom_range(9);
        if (pick < 2) offer(ChNl);
        else if (pick < 9) offer(ChQuote);
        // else left unterminated
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 4)) offer(CharW'($urandom_range(255, lo)));
      end else begin
        offer(random_sym_extra());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Register access
  // ---------------------------------------------------------------------------
  task automatic apb_write(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == RegHalt) halt_reg = data[0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_halt(input logic value);
    apb_write(RegHalt, DataW'(value));
    // then read the register back
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= RegHalt;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== DataW'(halt_reg))
      report_mismatch("halt read-back", prdata, 32'(halt_reg));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Hold the sender until every label is back and the block is quiet
  task automatic wait_drained();
    while (pending_chars.size() != 0 || in_bus.valid || expected_labels.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Character driver
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_beat) begin
      if (pending_chars.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_bus.char_in <= pending_chars.pop_front();
        in_bus.valid   <= 1'b1;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Result ready: random stalls plus one long hold-off to back the block up
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      out_bus.ready <= 1'b0;
    end else if (!hold_done && out_beats >= HoldAtBeat) begin
      hold_left     <= HoldCycles;
      hold_done     <= 1'b1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check result beats, then predict the accepted character
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_side
    scan_result_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      out_beats <= out_beats + 1;
      if (expected_labels.size() == 0) begin
        report_mismatch("result beat with nothing expected", 32'(out_bus.char_out), 0);
      end else begin
        want = expected_labels.pop_front();
        if (out_bus.char_role !== want.role)
          report_mismatch("char_role", 32'(out_bus.char_role), 32'(want.role));
        if (out_bus.token_kind !== want.kind)
          report_mismatch("token_kind", 32'(out_bus.token_kind), 32'(want.kind));
        if (out_bus.closes_previous !== want.closes)
          report_mismatch("closes_previous", 32'(out_bus.closes_previous),
                          32'(want.closes));
        if (out_bus.char_position !== want.pos)
          report_mismatch("char_position", 32'(out_bus.char_position), 32'(want.pos));
        if (out_bus.char_out !== want.ch)
          report_mismatch("char_out", 32'(out_bus.char_out), 32'(want.ch));
      end
    end
    if (rst_ni && in_bus.valid && in_bus.ready)
      expected_labels.push_back(classify_char(in_bus.char_in));
    in_beat <= rst_ni && in_bus.valid && in_bus.ready;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [CharW-1:0] opening [25];

    rst_ni         = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.char_in = '0;
    out_bus.ready  = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    halt_reg       = 1'b0;
    cur_mode       = MODE_BETWEEN;
    tok_open       = 1'b0;
    next_pos       = '0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Phase 1: sender sparse-ish, receiver mostly stalled
    tx_idle_pct = 38;
    rx_idle_pct = 69;
    set_halt(1'b0);

    // punctuation, string closed by newline, symbol over every extra char,
    // symbol closed by space, tab and CR as unknowns, high bytes, symbol
    // closed by an unknown, string holding a space, symbol closed by punctuation
    opening = '{ChLBrc, ChQuote, ChLowA, ChNl, ChUpZ, ChUscore, ChPlus, ChHash,
                ChEq, ChColon, ChMinus, ChSlash, Ch9, ChSpace, ChTab, ChCr,
                8'hFF, 8'h80, Ch0, ChAt, ChQuote, ChSpace, ChQuote, ChLowZ, ChQmark};
    foreach (opening[i]) offer(opening[i]);
    queue_text(400, 1'b0);
    wait_drained();

    // Writes to the empty slot are dropped; halted text may carry zero bytes
    apb_write(RegSpare, DataW'(1));
    set_halt(1'b1);
    queue_text(40, 1'b1);
    wait_drained();
    set_halt(1'b0);

    // Phase 2: roles swapped
    tx_idle_pct = 69;
    rx_idle_pct = 38;
    queue_text(400, 1'b0);
    wait_drained();

    // Phase 3: full rate up to the stream length
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    queue_text(StreamLength - queued_total, 1'b0);
    // unterminated string cut by end of data, then characters after the end
    offer(ChSpace);
    offer(ChQuote);
    offer(ChLowA);
    offer(ChZero);
    offer(ChLowA);
    offer(ChZero);
    offer(8'hFF);
    wait_drained();
    repeat (8) @(posedge clk_i);

    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: token_boundary_scanner.f
+incdir+hw/rtl
hw/rtl/tbs_pkg.sv
hw/rtl/tbs_if.sv
hw/rtl/tbs_char_class.sv
hw/rtl/tbs_scan_core.sv
hw/rtl/token_boundary_scanner.sv
tb/sv/tb_token_boundary_scanner.sv
